// ----- hdl/rab_pkg.sv -----
`timescale 1ns / 1ps

package rab_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_OPACITY  = 2'd0;
  localparam logic [1:0] CFG_DST_ALPHA = 2'd1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Q1.15 opacity
  localparam logic [15:0] OPACITY_ONE  = 16'h8000;
  localparam logic [23:0] OPACITY_HALF = 24'h004000;
  localparam int unsigned QShift       = 15;

  // RGB565 layout
  localparam int unsigned RedLsb   = 11;
  localparam int unsigned GreenLsb = 5;
  localparam logic [7:0]  FULL_ALPHA = 8'd255;

  // Width of one channel's blended sum: 63 * 255 fits in 14 bits
  localparam int unsigned SumW  = 14;
  localparam int unsigned ChanW = 6;

  typedef enum logic [2:0] {
    MODE_COPY  = 3'b001,
    MODE_SKIP  = 3'b010,
    MODE_BLEND = 3'b100
  } rab_mode_e;

  // Stage advance strobes handed to the channel datapaths
  typedef struct packed {
    logic s2;
    logic s3;
  } rab_adv_t;

  // Exact x / 255 for x below 16320
  function automatic logic [ChanW-1:0] div255(input logic [SumW-1:0] x);
    logic [SumW:0] t;
    t = {1'b0, x} + {9'd0, x[SumW-1:8]} + {{SumW{1'b0}}, 1'b1};
    return t[SumW-1:8];
  endfunction

endpackage

// ----- hdl/rgb565_alpha_blend.sv -----
`timescale 1ns / 1ps

// Channel    Signals                              Direction
// input      in_valid_i / in_ready_o, src/dst     in
// output     out_valid_o / out_ready_i, results   out
// config     cfg_we_i, cfg_index_i, cfg_data_i    in, write only
//
// Three register stages: effective alpha, channel products, divide and
// select. One item enters every cycle unless out_ready_i stalls the pipe.
// Each stage moves on when it is empty or the stage after it moves, so
// bubbles are squeezed out and a stall loses nothing.
// Reset clears the stage valid bits and sets opacity to 1.0, no alpha plane.
module rgb565_alpha_blend import rab_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         src_pixel_i,
  input  logic [7:0]          src_alpha_i,
  input  logic [15:0]         dst_pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         out_pixel_o,
  output logic                pixel_write_o,
  output logic [7:0]          out_alpha_o,
  output logic                alpha_write_o
);

  logic [15:0] opacity_q;
  logic        dst_alpha_q;

  logic        v1_q, v2_q, v3_q;
  logic        en1, en2, en3;
  rab_adv_t    adv;

  logic [15:0] op_sat;
  logic [23:0] sa_sum;
  rab_mode_e   mode_d;

  logic [15:0] src1_q, dst1_q;
  logic [7:0]  sa1_q;
  rab_mode_e   mode1_q;
  logic        dha1_q;

  logic [15:0] src2_q, dst2_q;
  logic [7:0]  sa2_q;
  rab_mode_e   mode2_q;
  logic        dha2_q;

  logic [SumW-1:0] r_sum, g_sum, b_sum;
  logic [ChanW-1:0] r_q6, g_q6, b_q6;
  logic [15:0] blend_px;

  logic [15:0] pix_d, pix_q;
  logic        pwr_d, pwr_q;
  logic [7:0]  oal_d, oal_q;
  logic        awr_d, awr_q;

  // Configuration registers; drop writes to spare indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q   <= OPACITY_ONE;
      dst_alpha_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OPACITY: begin
          opacity_q <= cfg_data_i;
        end
        CFG_DST_ALPHA: begin
          dst_alpha_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign adv.s2     = en2;
  assign adv.s3     = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: saturate opacity, scale alpha with rounding, pick the mode
  assign op_sat = (opacity_q > OPACITY_ONE) ? OPACITY_ONE : opacity_q;
  assign sa_sum = src_alpha_i * op_sat + OPACITY_HALF;

  always_comb begin
    if (op_sat == 16'd0) begin
      mode_d = MODE_COPY;
    end else if (sa_sum[QShift+7:QShift] == 8'd0) begin
      mode_d = MODE_SKIP;
    end else begin
      mode_d = MODE_BLEND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      src1_q  <= src_pixel_i;
      dst1_q  <= dst_pixel_i;
      sa1_q   <= sa_sum[QShift+7:QShift];
      mode1_q <= mode_d;
      dha1_q  <= dst_alpha_q;
    end
  end

  // Stage 2: weighted channel sums, carry the item alongside
  rab_chan_mul u_red (
    .clk_i (clk_i),
    .en_i  (adv.s2),
    .src_i ({1'b0, src1_q[15:RedLsb]}),
    .dst_i ({1'b0, dst1_q[15:RedLsb]}),
    .sa_i  (sa1_q),
    .sum_o (r_sum)
  );

  rab_chan_mul u_green (
    .clk_i (clk_i),
    .en_i  (adv.s2),
    .src_i (src1_q[RedLsb-1:GreenLsb]),
    .dst_i (dst1_q[RedLsb-1:GreenLsb]),
    .sa_i  (sa1_q),
    .sum_o (g_sum)
  );

  rab_chan_mul u_blue (
    .clk_i (clk_i),
    .en_i  (adv.s2),
    .src_i ({1'b0, src1_q[GreenLsb-1:0]}),
    .dst_i ({1'b0, dst1_q[GreenLsb-1:0]}),
    .sa_i  (sa1_q),
    .sum_o (b_sum)
  );

  always_ff @(posedge clk_i) begin
    if (adv.s2) begin
      src2_q  <= src1_q;
      dst2_q  <= dst1_q;
      sa2_q   <= sa1_q;
      mode2_q <= mode1_q;
      dha2_q  <= dha1_q;
    end
  end

  // Stage 3: divide by 255, repack and select the result
  assign r_q6     = div255(r_sum);
  assign g_q6     = div255(g_sum);
  assign b_q6     = div255(b_sum);
  assign blend_px = {r_q6[4:0], g_q6, b_q6[4:0]};

  always_comb begin
    unique case (mode2_q)
      MODE_COPY: begin
        pix_d = src2_q;
        pwr_d = 1'b1;
        oal_d = 8'd0;
        awr_d = 1'b0;
      end
      MODE_SKIP: begin
        pix_d = dst2_q;
        pwr_d = 1'b0;
        oal_d = 8'd0;
        awr_d = 1'b0;
      end
      MODE_BLEND: begin
        pix_d = blend_px;
        pwr_d = 1'b1;
        oal_d = sa2_q;
        awr_d = dha2_q;
      end
      default: begin
        pix_d = dst2_q;
        pwr_d = 1'b0;
        oal_d = 8'd0;
        awr_d = 1'b0;
      end
    endcase
  end

  // Output register: hold the item until taken
  always_ff @(posedge clk_i) begin
    if (adv.s3) begin
      pix_q <= pix_d;
      pwr_q <= pwr_d;
      oal_q <= oal_d;
      awr_q <= awr_d;
    end
  end

  assign out_valid_o   = v3_q;
  assign out_pixel_o   = pix_q;
  assign pixel_write_o = pwr_q;
  assign out_alpha_o   = oal_q;
  assign alpha_write_o = awr_q;

endmodule

// ----- hdl/rab_chan_mul.sv -----
`timescale 1ns / 1ps

module rab_chan_mul import rab_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ChanW-1:0] src_i,
  input  logic [ChanW-1:0] dst_i,
  input  logic [7:0]       sa_i,
  output logic [SumW-1:0]  sum_o
);

  logic [7:0]      nsa;
  logic [13:0]     src_prod;
  logic [13:0]     dst_prod;
  logic [SumW-1:0] sum_d;
  logic [SumW-1:0] sum_q;

  // Weight source by sa and destination by its complement
  assign nsa      = FULL_ALPHA - sa_i;
  assign src_prod = src_i * sa_i;
  assign dst_prod = dst_i * nsa;
  assign sum_d    = src_prod + dst_prod;

  // Hold the weighted sum while the stage stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule
